FILE: src/qai_pkg.sv
package qai_pkg;

	localparam int QW = 32;

	// operation codes of the cmd field
	localparam logic CMD_ROTATE = 1'b0;
	localparam logic CMD_LOAD   = 1'b1;

	typedef struct packed {
		logic              cmd;
		logic signed [31:0] roll_step;
		logic signed [31:0] pitch_step;
		logic signed [31:0] yaw_step;
		logic              body_frame;
		logic signed [31:0] load_w;
		logic signed [31:0] load_x;
		logic signed [31:0] load_y;
		logic signed [31:0] load_z;
	} req_t;

	typedef struct packed {
		logic signed [31:0] out_w;
		logic signed [31:0] out_x;
		logic signed [31:0] out_y;
		logic signed [31:0] out_z;
		logic              zero_length;
	} rsp_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_UPD,
		ST_SQR,
		ST_SQRT,
		ST_DIV,
		ST_DONE
	} state_t;

	// clamp a 67-bit signed sum to the 32-bit signed range
	function automatic logic signed [31:0] sat32(input logic signed [66:0] v);
		logic signed [31:0] r;
		if (v > 67'sd2147483647) begin
			r = 32'sh7fffffff;
		end else if (v < -67'sd2147483648) begin
			r = 32'sh80000000;
		end else begin
			r = v[31:0];
		end
		return r;
	endfunction

endpackage

FILE: src/qai_if.sv
interface qai_req_if import qai_pkg::*; ();
	logic valid;
	logic ready;
	req_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

interface qai_rsp_if import qai_pkg::*; ();
	logic valid;
	logic ready;
	rsp_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

FILE: src/qai_sqrt.sv
module qai_sqrt import qai_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] s,
	output logic        done,
	output logic [31:0] root
);

	logic [63:0] rem_q;
	logic [63:0] res_q;
	logic [63:0] bit_q;
	logic        busy_q;
	logic        done_q;
	logic [64:0] trial;

	assign trial = {1'b0, res_q} + {1'b0, bit_q};

	// one result bit per cycle, 32 steps
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
			end else if (busy_q && bit_q == 64'd1) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= s;
			res_q <= '0;
			bit_q <= 64'd1 << 62;
		end else if (busy_q) begin
			if ({1'b0, rem_q} >= trial) begin
				rem_q <= 64'({1'b0, rem_q} - trial);
				res_q <= (res_q >> 1) + bit_q;
			end else begin
				res_q <= res_q >> 1;
			end
			bit_q <= bit_q >> 2;
		end
	end

	assign done = done_q;
	assign root = res_q[31:0];

endmodule

FILE: src/qai_div.sv
module qai_div import qai_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] num,
	input  logic [32:0] den,
	output logic        done,
	output logic        ovf,
	output logic [32:0] quo
);

	logic [32:0] rem_q;
	logic [32:0] lo_q;
	logic [32:0] quo_q;
	logic [5:0]  cnt_q;
	logic        busy_q;
	logic        done_q;
	logic        ovf_q;
	logic [33:0] t;
	logic        fits;

	// quotient wider than 33 bits is flagged, never computed
	assign fits = {2'b00, num} < {den, 33'd0};
	assign t    = {rem_q, lo_q[32]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= fits;
				done_q <= !fits;
			end else if (busy_q && cnt_q == 6'd0) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	// restoring division, one quotient bit per cycle
	always_ff @(posedge clk) begin
		if (start) begin
			ovf_q <= !fits;
			rem_q <= {2'b00, num[63:33]};
			lo_q  <= num[32:0];
			quo_q <= '0;
			cnt_q <= 6'd32;
		end else if (busy_q) begin
			if (t >= {1'b0, den}) begin
				rem_q <= 33'(t - {1'b0, den});
				quo_q <= {quo_q[31:0], 1'b1};
			end else begin
				rem_q <= t[32:0];
				quo_q <= {quo_q[31:0], 1'b0};
			end
			lo_q  <= {lo_q[31:0], 1'b0};
			cnt_q <= cnt_q - 6'd1;
		end
	end

	assign done = done_q;
	assign ovf  = ovf_q;
	assign quo  = quo_q;

endmodule

FILE: src/quaternion_attitude_integrator_unit.sv
// channel  dir  payload                                        handshake
// req      in   cmd, roll/pitch/yaw_step, body_frame, load_wxyz valid/ready
// rsp      out  out_w, out_x, out_y, out_z, zero_length          valid/ready
//
// One item at a time. A load goes straight to posting. A rotate uses the shared
// 32x32 multiplier for the increment, updates, forms the squared length, takes
// the bit-serial square root, runs the bit-serial divider that normalizes each
// component, posts and goes back to idle. Zero length skips root and divider;
// all components at the minimum skip the root; an overflowing quotient skips its division.
// Reset puts the orientation at identity. The result waits in an output
// register; a stalled rsp holds the block in its final state.
module quaternion_attitude_integrator_unit import qai_pkg::*; #(
	parameter int FRAC_BITS = 30
) (
	input  logic   clk,
	input  logic   arst_n,
	qai_req_if.sink   req,
	qai_rsp_if.source rsp
);

	state_t state_q, state_d;

	logic signed [31:0] q_q   [4];
	logic signed [31:0] v_q   [4];
	logic signed [31:0] nv_q  [4];
	logic signed [65:0] acc_q [4];
	logic signed [31:0] step_q [3];
	logic               body_q;
	logic               zl_q;
	logic [3:0]         k_q;
	logic [1:0]         ci_q;
	logic [64:0]        s_q;
	logic [32:0]        len_q;

	logic signed [63:0] prod_s1;
	logic               pv_s1;
	logic [1:0]         pdst_s1;
	logic               pneg_s1;

	logic               sqrt_go_q, div_go_q;
	logic               sqrt_done, div_done, div_ovf;
	logic [31:0]        sqrt_root;
	logic [32:0]        div_quo;

	rsp_t               out_q;
	logic               out_valid_q;

	// multiplier operand select and routing
	logic signed [31:0] ma, mb;
	logic               issue;
	logic [1:0]         dst;
	logic               neg;

	logic signed [31:0] cur_v;
	logic [31:0]        mag;
	logic [63:0]        num;
	logic signed [31:0] scaled;
	logic signed [63:0] hp;
	logic signed [31:0] upd_v [4];

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (req.valid) begin
					state_d = (req.data.cmd == CMD_LOAD) ? ST_DONE : ST_MUL;
				end
			end
			ST_MUL: if (k_q == 4'd12) state_d = ST_UPD;
			ST_UPD: state_d = ST_SQR;
			ST_SQR: begin
				if (k_q == 4'd5) begin
					if (s_q == '0) state_d = ST_DONE;
					else if (s_q[64]) state_d = ST_DIV;
					else state_d = ST_SQRT;
				end
			end
			ST_SQRT: if (sqrt_done) state_d = ST_DIV;
			ST_DIV: if (div_done && ci_q == 2'd3) state_d = ST_DONE;
			ST_DONE: if (!out_valid_q || rsp.ready) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// outputs: increment product schedule and squaring
	always_comb begin
		ma    = '0;
		mb    = '0;
		issue = 1'b0;
		dst   = 2'd0;
		neg   = 1'b0;
		case (state_q)
			ST_MUL: begin
				issue = (k_q < 4'd12);
				case (k_q)
					4'd0:  begin ma = step_q[0]; mb = q_q[1]; dst = 2'd0; neg = !body_q; end
					4'd1:  begin ma = step_q[1]; mb = q_q[2]; dst = 2'd0; neg = !body_q; end
					4'd2:  begin ma = step_q[2]; mb = q_q[3]; dst = 2'd0; neg = !body_q; end
					4'd3:  begin ma = step_q[0]; mb = q_q[0]; dst = 2'd1; neg = body_q; end
					4'd4:  begin ma = step_q[1]; mb = q_q[3]; dst = 2'd1; neg = 1'b0; end
					4'd5:  begin ma = step_q[2]; mb = q_q[2]; dst = 2'd1; neg = 1'b1; end
					4'd6:  begin ma = step_q[1]; mb = q_q[0]; dst = 2'd2; neg = body_q; end
					4'd7:  begin ma = step_q[2]; mb = q_q[1]; dst = 2'd2; neg = 1'b0; end
					4'd8:  begin ma = step_q[0]; mb = q_q[3]; dst = 2'd2; neg = 1'b1; end
					4'd9:  begin ma = step_q[2]; mb = q_q[0]; dst = 2'd3; neg = body_q; end
					4'd10: begin ma = step_q[0]; mb = q_q[2]; dst = 2'd3; neg = 1'b0; end
					4'd11: begin ma = step_q[1]; mb = q_q[1]; dst = 2'd3; neg = 1'b1; end
					default: begin ma = '0; mb = '0; end
				endcase
			end
			ST_SQR: begin
				issue = (k_q < 4'd4);
				ma    = v_q[k_q[1:0]];
				mb    = v_q[k_q[1:0]];
			end
			default: begin
				issue = 1'b0;
			end
		endcase
	end

	assign req.ready = (state_q == ST_IDLE);

	// halved product, floor
	assign hp = prod_s1 >>> 1;

	// new components: component plus floor-shifted delta, clamped
	always_comb begin
		logic signed [65:0] d;
		for (int i = 0; i < 4; i++) begin
			d = acc_q[i] >>> FRAC_BITS;
			upd_v[i] = sat32({{35{q_q[i][31]}}, q_q[i]} + {d[65], d});
		end
	end

	// normalization operands for the current component
	assign cur_v = v_q[ci_q];
	assign mag   = cur_v[31] ? 32'(-cur_v) : 32'(cur_v);
	assign num   = (64'(mag) << FRAC_BITS) + 64'(len_q >> 1);

	always_comb begin
		if (cur_v[31]) begin
			if (div_ovf || div_quo > 33'h080000000) scaled = 32'sh80000000;
			else scaled = -$signed(div_quo[31:0]);
		end else begin
			if (div_ovf || div_quo > 33'h07fffffff) scaled = 32'sh7fffffff;
			else scaled = $signed(div_quo[31:0]);
		end
	end

	qai_sqrt u_sqrt (
		.clk   (clk),
		.arst_n(arst_n),
		.start (sqrt_go_q),
		.s     (s_q[63:0]),
		.done  (sqrt_done),
		.root  (sqrt_root)
	);

	qai_div u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (div_go_q),
		.num   (num),
		.den   (len_q),
		.done  (div_done),
		.ovf   (div_ovf),
		.quo   (div_quo)
	);

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			pv_s1       <= 1'b0;
			sqrt_go_q   <= 1'b0;
			div_go_q    <= 1'b0;
			out_valid_q <= 1'b0;
			q_q[0]      <= 32'(64'd1 << FRAC_BITS);
			q_q[1]      <= '0;
			q_q[2]      <= '0;
			q_q[3]      <= '0;
		end else begin
			state_q   <= state_d;
			pv_s1     <= issue;
			sqrt_go_q <= (state_q == ST_SQR) && (k_q == 4'd5) && (s_q != '0) && !s_q[64];
			div_go_q  <= ((state_q == ST_SQR) && (k_q == 4'd5) && s_q[64]) ||
			             ((state_q == ST_SQRT) && sqrt_done) ||
			             ((state_q == ST_DIV) && div_done && ci_q != 2'd3);
			if (state_q == ST_IDLE && req.valid && req.data.cmd == CMD_LOAD) begin
				q_q[0] <= req.data.load_w;
				q_q[1] <= req.data.load_x;
				q_q[2] <= req.data.load_y;
				q_q[3] <= req.data.load_z;
			end else if (state_q == ST_DIV && div_done && ci_q == 2'd3) begin
				q_q[0] <= nv_q[0];
				q_q[1] <= nv_q[1];
				q_q[2] <= nv_q[2];
				q_q[3] <= scaled;
			end
			// output register
			if (state_q == ST_DONE && (!out_valid_q || rsp.ready)) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		prod_s1 <= ma * mb;
		pdst_s1 <= dst;
		pneg_s1 <= neg;
		case (state_q)
			ST_IDLE: begin
				step_q[0] <= req.data.roll_step;
				step_q[1] <= req.data.pitch_step;
				step_q[2] <= req.data.yaw_step;
				body_q    <= req.data.body_frame;
				zl_q      <= 1'b0;
				k_q       <= '0;
				for (int i = 0; i < 4; i++) acc_q[i] <= '0;
			end
			ST_MUL: begin
				k_q <= k_q + 4'd1;
				if (pv_s1) begin
					acc_q[pdst_s1] <= pneg_s1 ? acc_q[pdst_s1] - 66'(hp)
					                          : acc_q[pdst_s1] + 66'(hp);
				end
			end
			ST_UPD: begin
				for (int i = 0; i < 4; i++) v_q[i] <= upd_v[i];
				s_q <= '0;
				k_q <= '0;
			end
			ST_SQR: begin
				// last square lands in the cycle after its issue
				k_q <= k_q + 4'd1;
				if (pv_s1) s_q <= s_q + {1'b0, prod_s1};
				if (k_q == 4'd5) begin
					zl_q  <= (s_q == '0);
					len_q <= 33'h100000000;
					ci_q  <= '0;
				end
			end
			ST_SQRT: begin
				if (sqrt_done) len_q <= {1'b0, sqrt_root};
			end
			ST_DIV: begin
				if (div_done) begin
					nv_q[ci_q] <= scaled;
					ci_q       <= ci_q + 2'd1;
				end
			end
			ST_DONE: begin
				if (!out_valid_q || rsp.ready) begin
					out_q.out_w       <= q_q[0];
					out_q.out_x       <= q_q[1];
					out_q.out_y       <= q_q[2];
					out_q.out_z       <= q_q[3];
					out_q.zero_length <= zl_q;
				end
			end
			default: begin
				k_q <= k_q;
			end
		endcase
	end

	assign rsp.valid = out_valid_q;
	assign rsp.data  = out_q;

endmodule

FILE: sim/tb_top.sv
module tb_top;
	import qai_pkg::*;

	logic clk;
	logic arst_n;

	qai_req_if req_ch();
	qai_rsp_if rsp_ch();

	quaternion_attitude_integrator_unit #(.FRAC_BITS(30)) uut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_ch.sink),
		.rsp(rsp_ch.source)
	);

	localparam int FRAC = 30;
	localparam longint LIMIT = 2000000;

	// predicted orientation and queue of expected results
	logic signed [31:0] att_q [4];
	rsp_t pending_rsp [$];
	int mismatches;
	int hold_cycles;
	longint cycle_cnt;

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// floor halving of an exact step*component product
	function automatic logic signed [127:0] half_mul(input logic signed [31:0] s,
			input logic signed [31:0] c);
		logic signed [127:0] p;
		p = 128'(s) * 128'(c);
		return p >>> 1;
	endfunction

	function automatic logic signed [31:0] clamp32(input logic signed [127:0] v);
		if (v > 128'sd2147483647) return 32'sh7fffffff;
		if (v < -128'sd2147483648) return 32'sh80000000;
		return v[31:0];
	endfunction

	function automatic logic [127:0] int_sqrt(input logic [127:0] s);
		logic [127:0] res;
		logic [127:0] b;
		res = 0;
		b = 128'd1 << 66;
		while (b > s) b = b >> 2;
		while (b != 0) begin
			if (s >= res + b) begin
				s = s - (res + b);
				res = (res >> 1) + b;
			end else begin
				res = res >> 1;
			end
			b = b >> 2;
		end
		return res;
	endfunction

	function automatic logic signed [31:0] normalize(input logic signed [31:0] v,
			input logic [127:0] len);
		logic [127:0] mag;
		logic [127:0] q;
		mag = v < 0 ? 128'(-128'(v)) : 128'(v);
		q = ((mag << FRAC) + (len >> 1)) / len;
		if (v < 0) begin
			if (q > 128'd2147483648) return 32'sh80000000;
			return -32'(q);
		end
		if (q > 128'd2147483647) return 32'sh7fffffff;
		return 32'(q);
	endfunction

	// advance the predicted orientation by one item
	function automatic rsp_t predict_attitude(input req_t it);
		rsp_t r;
		logic signed [127:0] d [4];
		logic signed [127:0] sg;
		logic signed [31:0] v [4];
		logic [127:0] s;
		logic [127:0] len;
		r.zero_length = 1'b0;
		if (it.cmd == CMD_LOAD) begin
			att_q[0] = it.load_w;
			att_q[1] = it.load_x;
			att_q[2] = it.load_y;
			att_q[3] = it.load_z;
		end else begin
			sg = it.body_frame ? -128'sd1 : 128'sd1;
			d[0] = -sg * (half_mul(it.roll_step, att_q[1]) + half_mul(it.pitch_step, att_q[2])
				+ half_mul(it.yaw_step, att_q[3]));
			d[1] = sg * half_mul(it.roll_step, att_q[0]) + half_mul(it.pitch_step, att_q[3])
				- half_mul(it.yaw_step, att_q[2]);
			d[2] = sg * half_mul(it.pitch_step, att_q[0]) + half_mul(it.yaw_step, att_q[1])
				- half_mul(it.roll_step, att_q[3]);
			d[3] = sg * half_mul(it.yaw_step, att_q[0]) + half_mul(it.roll_step, att_q[2])
				- half_mul(it.pitch_step, att_q[1]);
			s = 0;
			for (int i = 0; i < 4; i++) begin
				v[i] = clamp32(128'(att_q[i]) + (d[i] >>> FRAC));
				s = s + 128'(128'(v[i]) * 128'(v[i]));
			end
			if (s == 0) begin
				r.zero_length = 1'b1;
			end else begin
				len = int_sqrt(s);
				for (int i = 0; i < 4; i++) att_q[i] = normalize(v[i], len);
			end
		end
		r.out_w = att_q[0];
		r.out_x = att_q[1];
		r.out_y = att_q[2];
		r.out_z = att_q[3];
		return r;
	endfunction

	function automatic int gap_len();
		int k;
		k = $urandom_range(0, 99);
		if (k < 45) return 0;
		if (k < 92) return $urandom_range(1, 3);
		return $urandom_range(10, 60);
	endfunction

	// offer one item, wait for acceptance, record its expected result
	task automatic send_item(input req_t it);
		int g;
		g = gap_len();
		if (g > 0) begin
			req_ch.valid <= 1'b0;
			repeat (g) @(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.data <= it;
		do @(posedge clk); while (!req_ch.ready);
		pending_rsp.push_back(predict_attitude(it));
	endtask

	task automatic wait_drained();
		req_ch.valid <= 1'b0;
		while (pending_rsp.size() != 0) @(posedge clk);
	endtask

	function automatic logic [31:0] rnd_val();
		int k;
		k = $urandom_range(0, 9);
		if (k == 0) return 32'h8000_0000;
		if (k == 1) return 32'h7fff_ffff;
		if (k == 2) return 32'h0;
		return $urandom;
	endfunction

	function automatic logic signed [31:0] small_step();
		logic signed [31:0] v;
		v = $urandom_range(0, 2000000);
		return $urandom_range(0, 1) ? v : -v;
	endfunction

	function automatic req_t rotate_item(input logic signed [31:0] a, b, c,
			input logic frame);
		req_t it;
		it = '0;
		it.cmd = CMD_ROTATE;
		it.roll_step = a;
		it.pitch_step = b;
		it.yaw_step = c;
		it.body_frame = frame;
		it.load_w = $urandom;
		it.load_x = $urandom;
		it.load_y = $urandom;
		it.load_z = $urandom;
		return it;
	endfunction

	function automatic req_t load_item(input logic signed [31:0] w, x, y, z);
		req_t it;
		it = '0;
		it.cmd = CMD_LOAD;
		it.roll_step = $urandom;
		it.pitch_step = $urandom;
		it.yaw_step = $urandom;
		it.body_frame = 1'($urandom_range(0, 1));
		it.load_w = w;
		it.load_x = x;
		it.load_y = y;
		it.load_z = z;
		return it;
	endfunction

	// extremes, both frames, loads, zero length, all-minimum, tiny length
	task automatic test_directed();
		send_item(rotate_item(0, 0, 0, 1'b0));
		send_item(rotate_item(32'sd1 <<< 20, 32'sd5000, -32'sd7000, 1'b1));
		send_item(rotate_item(-32'sd300000, 32'sd1 <<< 22, 32'sd9, 1'b0));
		send_item(rotate_item(32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 1'b0));
		send_item(rotate_item(32'sh80000000, 32'sh80000000, 32'sh80000000, 1'b1));
		send_item(load_item(0, 0, 0, 0));
		send_item(rotate_item(32'sd12345, -32'sd999, 32'sd4, 1'b0));
		send_item(load_item(32'sh80000000, 32'sh80000000, 32'sh80000000, 32'sh80000000));
		send_item(rotate_item(0, 0, 0, 1'b1));
		send_item(load_item(32'sh80000000, 32'sh80000000, 32'sh80000000, 32'sh80000000));
		send_item(rotate_item(0, 0, 0, 1'b0));
		send_item(load_item(32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff));
		send_item(rotate_item(32'sh7fffffff, 32'sh80000000, 32'sd1, 1'b0));
		send_item(load_item(32'sd1, 0, 0, 0));
		send_item(rotate_item(0, 0, 0, 1'b0));
		send_item(load_item(0, -32'sd1, 32'sd1, 0));
		send_item(rotate_item(32'sd3, 0, 0, 1'b1));
		send_item(load_item(32'sh80000000, 0, 32'sh7fffffff, -32'sd1));
		send_item(rotate_item(32'sd1 <<< 29, -(32'sd1 <<< 29), 32'sd1 <<< 28, 1'b1));
		send_item(load_item(32'sd1 <<< 30, 0, 0, 0));
		wait_drained();
	endtask

	// mostly small realistic steps, some loads, some wild values
	task automatic test_random(input int n);
		int k;
		for (int i = 0; i < n; i++) begin
			k = $urandom_range(0, 99);
			if (k < 65)
				send_item(rotate_item(small_step(), small_step(), small_step(),
					1'($urandom_range(0, 1))));
			else if (k < 80)
				send_item(load_item(rnd_val(), rnd_val(), rnd_val(), rnd_val()));
			else if (k < 85)
				send_item(load_item($urandom_range(0, 3) - 1, $urandom_range(0, 3) - 1,
					$urandom_range(0, 3) - 1, $urandom_range(0, 3) - 1));
			else
				send_item(rotate_item(rnd_val(), rnd_val(), rnd_val(),
					1'($urandom_range(0, 1))));
		end
	endtask

	// stall the result side while items keep coming
	task automatic test_backpressure();
		hold_cycles = 400;
		test_random(6);
		wait_drained();
	endtask

	// result side: random stalls, long hold when requested
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_ch.ready <= 1'b0;
		end else if (hold_cycles > 0) begin
			hold_cycles <= hold_cycles - 1;
			rsp_ch.ready <= 1'b0;
		end else begin
			rsp_ch.ready <= (gap_len() == 0) || ($urandom_range(0, 3) == 0);
		end
	end

	// compare each accepted result with the oldest expectation
	always @(posedge clk) begin
		rsp_t exp_r;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (pending_rsp.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected result %h", rsp_ch.data);
			end else begin
				exp_r = pending_rsp.pop_front();
				if (exp_r !== rsp_ch.data) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch exp w%h x%h y%h z%h f%b got w%h x%h y%h z%h f%b",
							exp_r.out_w, exp_r.out_x, exp_r.out_y, exp_r.out_z,
							exp_r.zero_length, rsp_ch.data.out_w, rsp_ch.data.out_x,
							rsp_ch.data.out_y, rsp_ch.data.out_z, rsp_ch.data.zero_length);
				end
			end
		end
	end

	// run limit
	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt > LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	initial begin
		mismatches = 0;
		hold_cycles = 0;
		cycle_cnt = 0;
		att_q[0] = 32'sd1 <<< FRAC;
		att_q[1] = 0;
		att_q[2] = 0;
		att_q[3] = 0;
		arst_n = 1'b0;
		req_ch.valid = 1'b0;
		req_ch.data = '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random(500);
		test_backpressure();
		test_random(520);
		wait_drained();
		repeat (300) @(posedge clk);
		if (mismatches == 0 && pending_rsp.size() == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end
endmodule

FILE: quaternion_attitude_integrator_unit.f
src/qai_pkg.sv
src/qai_if.sv
src/qai_sqrt.sv
src/qai_div.sv
src/quaternion_attitude_integrator_unit.sv
sim/tb_top.sv
